### rtl/core/spnc_pkg.sv
// ----------------------------------------------------------------------------
// spnc_pkg
// shared types, character constants and the segment check for the path checker
// ----------------------------------------------------------------------------
package spnc_pkg;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] ch;
    logic       first_char;
    logic       last_char;
    logic       has_char;
    logic       absolute;
  } item_t;

  // classification of one character
  typedef struct packed {
    logic       is_sep;
    logic       is_letter;
    logic       is_colon;
    logic       is_dot;
    logic       is_dot_or_space;
    logic       forbidden;
    logic [6:0] upper;
  } char_class_t;

  // per-segment state
  typedef struct packed {
    logic            started;
    logic [2:0]      base_len;
    logic            base_ended;
    logic [3:0][6:0] letters;
    logic            tail_dot_or_space;
  } seg_t;

  // drive prefix positions
  localparam logic [1:0] PFX_LETTER = 2'd0;
  localparam logic [1:0] PFX_COLON  = 2'd1;
  localparam logic [1:0] PFX_SEP    = 2'd2;
  localparam logic [1:0] PFX_DONE   = 2'd3;

  localparam logic [7:0] CH_MIN       = 8'd32;
  localparam logic [7:0] CH_MAX       = 8'd126;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_LT        = 8'h3c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_QUESTION  = 8'h3f;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_BAR       = 8'h7c;
  localparam logic [7:0] CH_UP_A      = 8'h41;
  localparam logic [7:0] CH_UP_Z      = 8'h5a;
  localparam logic [7:0] CH_LO_A      = 8'h61;
  localparam logic [7:0] CH_LO_Z      = 8'h7a;
  localparam logic [6:0] CASE_OFFSET  = 7'h20;
  localparam logic [6:0] DIGIT_ONE    = 7'h31;
  localparam logic [6:0] DIGIT_NINE   = 7'h39;

  localparam logic [2:0] BASE_SAT = 3'd5;

  // reserved device names, upper case, first letter in the top bits
  localparam logic [20:0] NAME_CON = {7'h43, 7'h4f, 7'h4e};
  localparam logic [20:0] NAME_PRN = {7'h50, 7'h52, 7'h4e};
  localparam logic [20:0] NAME_AUX = {7'h41, 7'h55, 7'h58};
  localparam logic [20:0] NAME_NUL = {7'h4e, 7'h55, 7'h4c};
  localparam logic [20:0] NAME_COM = {7'h43, 7'h4f, 7'h4d};
  localparam logic [20:0] NAME_LPT = {7'h4c, 7'h50, 7'h54};

  localparam seg_t SEG_CLEAR = '0;

  function automatic logic seg_bad(input seg_t s);
    logic [20:0] head;
    logic        bad;
    head = {s.letters[0], s.letters[1], s.letters[2]};
    bad  = !s.started || s.tail_dot_or_space;
    if (s.base_len == 3'd3 &&
        (head == NAME_CON || head == NAME_PRN || head == NAME_AUX || head == NAME_NUL)) begin
      bad = 1'b1;
    end
    if (s.base_len == 3'd4 && s.letters[3] >= DIGIT_ONE && s.letters[3] <= DIGIT_NINE &&
        (head == NAME_COM || head == NAME_LPT)) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

endpackage

### rtl/core/safe_path_name_checker_core.sv
// ----------------------------------------------------------------------------
// safe_path_name_checker_core
// streaming safe path name check; while in_stall is low, one character word per cycle
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one character word with in_ch,
// in_first_char, in_last_char, in_has_char and in_absolute. A path is a run
// of words from a first mark to a last mark; in_absolute is sampled on the
// first word and then demands a drive prefix. A word without a character
// (in_has_char low) leaves the state alone unless it carries a first mark.
// Output channel: out_valid / out_stall carry out_path_safe, one word per
// path, produced by the word that carries the last mark.
// Throughput is one word per cycle while in_stall is low. An accepted last
// word reaches out_valid through the input register, then the result
// register, with the per-character state update between them.
// While out_stall holds a pending result, words that make no result keep
// flowing; a last word waits in the input register and in_stall rises only
// then. Synchronous reset (rst_n low) empties both registers and clears the
// path state; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module safe_path_name_checker_core #(
  parameter int MAX_RELATIVE_LENGTH = 240
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_first_char,
  input  logic       in_last_char,
  input  logic       in_has_char,
  input  logic       in_absolute,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_path_safe
);

  logic                  s1_valid_r, s1_valid_nxt;
  spnc_pkg::item_t       s1_item_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_safe_r;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  logic                  safe_nxt;
  spnc_pkg::char_class_t cls;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!s1_item_r.last_char || out_free);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = (advance && s1_item_r.last_char) || (out_valid_r && out_stall);

  spnc_char_class u_class (
    .ch  (s1_item_r.ch),
    .cls (cls)
  );

  spnc_path_state #(
    .MAX_RELATIVE_LENGTH (MAX_RELATIVE_LENGTH)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .item      (s1_item_r),
    .cls       (cls),
    .path_safe (safe_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{ch: in_ch, first_char: in_first_char, last_char: in_last_char,
                     has_char: in_has_char, absolute: in_absolute};
    end
    if (advance && s1_item_r.last_char) begin
      out_safe_r <= safe_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_safe = out_safe_r;

  // stall only ever holds back a last word blocked by a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_item_r.last_char && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // a last word that moves on always lands in the result register
  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.last_char) |=> out_valid_r)
    else $error("last word advanced without a result");

  // a word that makes no result never raises out_valid on its own
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(advance && s1_item_r.last_char)) |=> !out_valid_r)
    else $error("result appeared without a last word");

endmodule

### rtl/core/spnc_char_class.sv
// ----------------------------------------------------------------------------
// spnc_char_class
// classifies one path character: separators, prefix characters, illegal codes
// ----------------------------------------------------------------------------
module spnc_char_class (
  input  logic [7:0]           ch,
  output spnc_pkg::char_class_t cls
);

  logic [6:0] low7;

  assign low7 = ch[6:0];

  always_comb begin
    cls.is_sep          = (ch == spnc_pkg::CH_SLASH) || (ch == spnc_pkg::CH_BACKSLASH);
    cls.is_letter       = (ch >= spnc_pkg::CH_UP_A && ch <= spnc_pkg::CH_UP_Z) ||
                          (ch >= spnc_pkg::CH_LO_A && ch <= spnc_pkg::CH_LO_Z);
    cls.is_colon        = (ch == spnc_pkg::CH_COLON);
    cls.is_dot          = (ch == spnc_pkg::CH_DOT);
    cls.is_dot_or_space = (ch == spnc_pkg::CH_DOT) || (ch == spnc_pkg::CH_SPACE);
    cls.forbidden       = (ch < spnc_pkg::CH_MIN) || (ch > spnc_pkg::CH_MAX) ||
                          (ch == spnc_pkg::CH_COLON) || (ch == spnc_pkg::CH_STAR) ||
                          (ch == spnc_pkg::CH_QUESTION) || (ch == spnc_pkg::CH_QUOTE) ||
                          (ch == spnc_pkg::CH_LT) || (ch == spnc_pkg::CH_GT) ||
                          (ch == spnc_pkg::CH_BAR);
    // fold to upper case on the low seven bits
    if (low7 >= spnc_pkg::CH_LO_A[6:0] && low7 <= spnc_pkg::CH_LO_Z[6:0]) begin
      cls.upper = low7 - spnc_pkg::CASE_OFFSET;
    end else begin
      cls.upper = low7;
    end
  end

endmodule

### rtl/core/spnc_path_state.sv
// ----------------------------------------------------------------------------
// spnc_path_state
// per-path state registers, next-state logic and the pass/fail verdict
// ----------------------------------------------------------------------------
module spnc_path_state #(
  parameter int MAX_RELATIVE_LENGTH = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  spnc_pkg::item_t       item,
  input  spnc_pkg::char_class_t cls,
  output logic                  path_safe
);

  localparam int          LEN_W   = $clog2(MAX_RELATIVE_LENGTH + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_RELATIVE_LENGTH);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  logic             abs_r, abs_nxt;
  logic [1:0]       pfx_r, pfx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             failed_r, failed_nxt;
  spnc_pkg::seg_t   seg_r, seg_nxt;

  // state as seen after an optional restart on the first mark
  logic             abs_cur;
  logic [1:0]       pfx_cur;
  logic [LEN_W-1:0] len_cur;
  logic             failed_cur;
  spnc_pkg::seg_t   seg_cur;

  always_comb begin
    if (item.first_char) begin
      abs_cur    = item.absolute;
      pfx_cur    = spnc_pkg::PFX_LETTER;
      len_cur    = '0;
      failed_cur = 1'b0;
      seg_cur    = spnc_pkg::SEG_CLEAR;
    end else begin
      abs_cur    = abs_r;
      pfx_cur    = pfx_r;
      len_cur    = len_r;
      failed_cur = failed_r;
      seg_cur    = seg_r;
    end
  end

  always_comb begin
    abs_nxt    = abs_cur;
    pfx_nxt    = pfx_cur;
    len_nxt    = len_cur;
    failed_nxt = failed_cur;
    seg_nxt    = seg_cur;
    if (item.has_char) begin
      if (abs_cur && pfx_cur != spnc_pkg::PFX_DONE) begin
        case (pfx_cur)
          spnc_pkg::PFX_LETTER: failed_nxt = failed_cur | !cls.is_letter;
          spnc_pkg::PFX_COLON:  failed_nxt = failed_cur | !cls.is_colon;
          default:              failed_nxt = failed_cur | !cls.is_sep;
        endcase
        pfx_nxt = pfx_cur + 2'd1;
      end else begin
        // saturates one past the limit
        if (len_cur <= LEN_MAX) begin
          len_nxt = len_cur + LEN_ONE;
        end
        if (cls.is_sep) begin
          failed_nxt = failed_cur | spnc_pkg::seg_bad(seg_cur);
          seg_nxt    = spnc_pkg::SEG_CLEAR;
        end else begin
          failed_nxt                = failed_cur | cls.forbidden;
          seg_nxt.started           = 1'b1;
          seg_nxt.tail_dot_or_space = cls.is_dot_or_space;
          if (!seg_cur.base_ended) begin
            if (cls.is_dot) begin
              seg_nxt.base_ended = 1'b1;
            end else if (seg_cur.base_len < spnc_pkg::BASE_SAT) begin
              if (seg_cur.base_len < 3'd4) begin
                seg_nxt.letters[seg_cur.base_len[1:0]] = cls.upper;
              end
              seg_nxt.base_len = seg_cur.base_len + 3'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    path_safe = !failed_nxt &&
                !(abs_nxt && pfx_nxt != spnc_pkg::PFX_DONE) &&
                (len_nxt != '0) && (len_nxt <= LEN_MAX) &&
                !spnc_pkg::seg_bad(seg_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_r    <= 1'b0;
      pfx_r    <= spnc_pkg::PFX_LETTER;
      len_r    <= '0;
      failed_r <= 1'b0;
      seg_r    <= spnc_pkg::SEG_CLEAR;
    end else if (en) begin
      abs_r    <= abs_nxt;
      pfx_r    <= pfx_nxt;
      len_r    <= len_nxt;
      failed_r <= failed_nxt;
      seg_r    <= seg_nxt;
    end
  end

  // a failure sticks until the next path starts
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !item.first_char && failed_r) |=> failed_r)
    else $error("failed flag cleared inside a path");

  // the length never passes its saturation value
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX + LEN_ONE)
    else $error("relative length past saturation");

  // a relative path never moves through the drive prefix
  a_pfx_rel: assert property (@(posedge clk) disable iff (!rst_n)
    !abs_r |-> (pfx_r == spnc_pkg::PFX_LETTER))
    else $error("prefix position moved on a relative path");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming safe path name checker: a directed
// table then random paths, each result compared with the table or an in-bench path model
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_REL     = 240;
  localparam int WORD_TARGET = 1900;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 40;

  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_DASH       = 8'h2d;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_PASS,
    CHK_FAIL
  } check_src_t;

  typedef struct {
    spnc_pkg::item_t w;
    check_src_t      src;
  } directed_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_first_char;
  logic       in_last_char;
  logic       in_has_char;
  logic       in_absolute;
  logic       out_valid;
  logic       out_stall;
  logic       out_path_safe;

  safe_path_name_checker_core #(
    .MAX_RELATIVE_LENGTH(MAX_REL)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_first_char(in_first_char),
    .in_last_char (in_last_char),
    .in_has_char  (in_has_char),
    .in_absolute  (in_absolute),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_path_safe(out_path_safe)
  );

  // path model state
  logic           path_abs;
  logic [1:0]     pfx_pos;
  logic [7:0]     rel_len;
  spnc_pkg::seg_t cur_seg;
  logic           path_failed;

  logic            pending_verdicts[$];
  directed_row_t   directed_rows[$];
  spnc_pkg::item_t path_buf[$];

  int  mismatches    = 0;
  int  results_taken = 0;
  int  words_counted = 0;
  int  cycle_count   = 0;
  logic tx_burst;
  logic rx_burst;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_path();
    path_abs    = 1'b0;
    pfx_pos     = spnc_pkg::PFX_LETTER;
    rel_len     = '0;
    path_failed = 1'b0;
    cur_seg     = spnc_pkg::SEG_CLEAR;
  endfunction

  function automatic logic bad_byte(input logic [7:0] c);
    if (c < spnc_pkg::CH_MIN || c > spnc_pkg::CH_MAX) begin
      return 1'b1;
    end
    case (c)
      spnc_pkg::CH_COLON, spnc_pkg::CH_STAR, spnc_pkg::CH_QUESTION, spnc_pkg::CH_QUOTE,
      spnc_pkg::CH_LT, spnc_pkg::CH_GT, spnc_pkg::CH_BAR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // rejects an empty segment, a trailing dot or space, and device names before the first dot
  function automatic logic segment_rejected(input spnc_pkg::seg_t s);
    logic [20:0] stem;
    logic        numbered;
    stem     = {s.letters[0], s.letters[1], s.letters[2]};
    numbered = s.letters[3] >= spnc_pkg::DIGIT_ONE && s.letters[3] <= spnc_pkg::DIGIT_NINE;
    if (!s.started || s.tail_dot_or_space) begin
      return 1'b1;
    end
    case (s.base_len)
      3'd3: return stem == spnc_pkg::NAME_CON || stem == spnc_pkg::NAME_PRN ||
                   stem == spnc_pkg::NAME_AUX || stem == spnc_pkg::NAME_NUL;
      3'd4: return numbered && (stem == spnc_pkg::NAME_COM || stem == spnc_pkg::NAME_LPT);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    logic       sep;
    logic       letter;
    logic [6:0] up;
    sep    = c == spnc_pkg::CH_SLASH || c == spnc_pkg::CH_BACKSLASH;
    letter = (c >= spnc_pkg::CH_UP_A && c <= spnc_pkg::CH_UP_Z) ||
             (c >= spnc_pkg::CH_LO_A && c <= spnc_pkg::CH_LO_Z);
    if (path_abs && pfx_pos != spnc_pkg::PFX_DONE) begin
      case (pfx_pos)
        spnc_pkg::PFX_LETTER: if (!letter) path_failed = 1'b1;
        spnc_pkg::PFX_COLON:  if (c != spnc_pkg::CH_COLON) path_failed = 1'b1;
        default:              if (!sep) path_failed = 1'b1;
      endcase
      pfx_pos = pfx_pos + 2'd1;
      return;
    end
    if (rel_len <= MAX_REL) begin
      rel_len = rel_len + 8'd1;
    end
    if (sep) begin
      if (segment_rejected(cur_seg)) begin
        path_failed = 1'b1;
      end
      cur_seg = spnc_pkg::SEG_CLEAR;
      return;
    end
    if (bad_byte(c)) begin
      path_failed = 1'b1;
    end
    cur_seg.started           = 1'b1;
    cur_seg.tail_dot_or_space = c == spnc_pkg::CH_DOT || c == spnc_pkg::CH_SPACE;
    if (!cur_seg.base_ended) begin
      if (c == spnc_pkg::CH_DOT) begin
        cur_seg.base_ended = 1'b1;
      end else if (cur_seg.base_len < spnc_pkg::BASE_SAT) begin
        up = c[6:0];
        if (up >= spnc_pkg::CH_LO_A[6:0] && up <= spnc_pkg::CH_LO_Z[6:0]) begin
          up = up - spnc_pkg::CASE_OFFSET;
        end
        if (cur_seg.base_len < 3'd4) begin
          cur_seg.letters[cur_seg.base_len[1:0]] = up;
        end
        cur_seg.base_len = cur_seg.base_len + 3'd1;
      end
    end
  endfunction

  function automatic void judge_word(input spnc_pkg::item_t w, output logic has_verdict,
                                     output logic verdict);
    if (w.first_char) begin
      clear_path();
      path_abs = w.absolute;
    end
    if (w.has_char) begin
      take_byte(w.ch);
    end
    has_verdict = w.last_char;
    verdict = !path_failed && !(path_abs && pfx_pos != spnc_pkg::PFX_DONE) &&
              rel_len != 0 && rel_len <= MAX_REL && !segment_rejected(cur_seg);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_row(input logic [7:0] c, input int f, input int l,
                                  input int h, input int a, input check_src_t src);
    directed_row_t row;
    row.w            = '0;
    row.w.ch         = c;
    row.w.first_char = 1'(f);
    row.w.last_char  = 1'(l);
    row.w.has_char   = 1'(h);
    row.w.absolute   = 1'(a);
    row.src          = src;
    directed_rows.push_back(row);
  endfunction

  function automatic void put_blank();
    spnc_pkg::item_t w;
    w          = '0;
    w.ch       = 8'($urandom_range(0, 255));
    w.absolute = 1'($urandom_range(0, 1));
    path_buf.push_back(w);
  endfunction

  function automatic void put_char(input logic [7:0] c);
    spnc_pkg::item_t w;
    if ($urandom_range(0, 19) == 0) begin
      put_blank();
    end
    w          = '0;
    w.ch       = c;
    w.has_char = 1'b1;
    w.absolute = 1'($urandom_range(0, 1));
    path_buf.push_back(w);
  endfunction

  function automatic logic [7:0] pick_sep();
    return $urandom_range(0, 1) ? spnc_pkg::CH_SLASH : spnc_pkg::CH_BACKSLASH;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] k;
    k = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? spnc_pkg::CH_UP_A + k : spnc_pkg::CH_LO_A + k;
  endfunction

  function automatic logic [7:0] name_char();
    int         r;
    logic [7:0] k;
    r = $urandom_range(0, 99);
    k = 8'($urandom_range(0, 9));
    if (r < 62) return pick_letter();
    if (r < 76) return CH_ZERO + k;
    if (r < 82) return spnc_pkg::CH_DOT;
    if (r < 86) return spnc_pkg::CH_SPACE;
    if (r < 92) return r[0] ? CH_DASH : CH_UNDERSCORE;
    if (r < 97) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  // device names and near misses in mixed case
  function automatic string device_like(input int k);
    case (k)
      0:  return "con";
      1:  return "PRN";
      2:  return "Aux";
      3:  return "nul";
      4:  return "COM1";
      5:  return "lpt9";
      6:  return "com0";
      7:  return "LPT";
      8:  return "conx";
      9:  return "co";
      10: return "Com5";
      11: return "nUl";
      12: return "prn1";
      13: return "aux";
      14: return "lpt1";
      default: return "COM";
    endcase
  endfunction

  function automatic void put_segment();
    int    r;
    int    n;
    int    i;
    string s;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) put_char(name_char());
    end else if (r < 82) begin
      s = device_like($urandom_range(0, 15));
      for (i = 0; i < s.len(); i++) put_char(s[i]);
      if ($urandom_range(0, 2) == 0) begin
        put_char(spnc_pkg::CH_DOT);
        put_char(pick_letter());
      end
    end else if (r >= 88) begin
      // segment ending in a dot or a space
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) put_char(name_char());
      put_char(r < 94 ? spnc_pkg::CH_DOT : spnc_pkg::CH_SPACE);
    end
  endfunction

  function automatic void put_long(input int n);
    int         i;
    logic       prev_sep;
    logic [7:0] k;
    prev_sep = 1'b1;
    for (i = 0; i < n; i++) begin
      if (!prev_sep && i < n - 1 && $urandom_range(0, 7) == 0) begin
        put_char(pick_sep());
        prev_sep = 1'b1;
      end else begin
        k = 8'($urandom_range(0, 25));
        put_char(spnc_pkg::CH_LO_A + k);
        prev_sep = 1'b0;
      end
    end
  endfunction

  function automatic void build_path(input int long_len);
    logic       abs_path;
    int         nseg;
    int         k;
    int         r;
    logic [7:0] b;
    abs_path = $urandom_range(0, 9) < 3;
    if (abs_path) begin
      r = $urandom_range(0, 19);
      b = 8'($urandom_range(0, 255));
      put_char(r == 0 ? b : pick_letter());
      b = 8'($urandom_range(32, 126));
      put_char(r == 1 ? b : spnc_pkg::CH_COLON);
      put_char(r == 2 ? b : pick_sep());
    end
    if (long_len > 0) begin
      put_long(long_len);
    end else begin
      nseg = $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 4);
      if (nseg > 0 && $urandom_range(0, 19) == 0) put_char(pick_sep());
      for (k = 0; k < nseg; k++) begin
        if (k > 0) put_char(pick_sep());
        put_segment();
      end
      if (nseg > 0 && $urandom_range(0, 19) == 0) put_char(pick_sep());
    end
    if (path_buf.size() == 0 || $urandom_range(0, 11) == 0) begin
      put_blank();
    end
    path_buf[0].first_char                = 1'b1;
    path_buf[0].absolute                  = abs_path;
    path_buf[path_buf.size() - 1].last_char = 1'b1;
  endfunction

  function automatic void put_noise();
    int              n;
    int              i;
    spnc_pkg::item_t w;
    n = $urandom_range(1, 10);
    for (i = 0; i < n; i++) begin
      w.ch         = 8'($urandom_range(0, 255));
      w.first_char = 1'($urandom_range(0, 1));
      w.last_char  = 1'($urandom_range(0, 1));
      w.has_char   = 1'($urandom_range(0, 1));
      w.absolute   = 1'($urandom_range(0, 1));
      path_buf.push_back(w);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input spnc_pkg::item_t w, input check_src_t src);
    int   gap;
    logic has_verdict;
    logic verdict;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_ch         <= w.ch;
    in_first_char <= w.first_char;
    in_last_char  <= w.last_char;
    in_has_char   <= w.has_char;
    in_absolute   <= w.absolute;
    do @(posedge clk); while (in_stall);
    judge_word(w, has_verdict, verdict);
    if (has_verdict) begin
      if (src == CHK_PASS) verdict = 1'b1;
      else if (src == CHK_FAIL) verdict = 1'b0;
      pending_verdicts.push_back(verdict);
    end
    if (w.has_char || w.last_char) begin
      words_counted++;
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s, expected path_safe=%b got %b", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("result word with nothing expected", 1'bx, out_path_safe);
      end else if (pending_verdicts[0] !== out_path_safe) begin
        flag_mismatch("wrong verdict", pending_verdicts[0], out_path_safe);
        void'(pending_verdicts.pop_front());
      end else begin
        void'(pending_verdicts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stall per word, one long hold to back the block up
  initial begin
    int hold;
    out_stall = 1'b0;
    rx_burst  = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) rx_burst = ~rx_burst;
      if (results_taken == HOLD_AT) hold = HOLD_CYCLES;
      else hold = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    int i;
    int r;
    int path_idx;
    int long_len;
    in_valid      = 1'b0;
    in_ch         = '0;
    in_first_char = 1'b0;
    in_last_char  = 1'b0;
    in_has_char   = 1'b0;
    in_absolute   = 1'b0;
    rst_n         = 1'b0;
    tx_burst      = 1'b0;
    clear_path();

    // empty path and single characters at the byte extremes
    add_row(8'h00, 1, 1, 0, 0, CHK_FAIL);
    add_row("a", 1, 1, 1, 0, CHK_PASS);
    add_row(8'hff, 1, 1, 1, 0, CHK_FAIL);
    add_row(8'h00, 1, 1, 1, 0, CHK_FAIL);
    add_row(spnc_pkg::CH_MAX, 1, 1, 1, 0, CHK_PASS);
    add_row(spnc_pkg::CH_SPACE, 1, 1, 1, 0, CHK_FAIL);
    // drive prefix then one character
    add_row(spnc_pkg::CH_UP_Z, 1, 0, 1, 1, CHK_MODEL);
    add_row(spnc_pkg::CH_COLON, 0, 0, 1, 0, CHK_MODEL);
    add_row(spnc_pkg::CH_BACKSLASH, 0, 0, 1, 0, CHK_MODEL);
    add_row(spnc_pkg::CH_LO_Z, 0, 1, 1, 0, CHK_PASS);
    // path ending inside the prefix
    add_row("a", 1, 0, 1, 1, CHK_MODEL);
    add_row(spnc_pkg::CH_COLON, 0, 1, 1, 1, CHK_FAIL);
    // separator at the end
    add_row("a", 1, 0, 1, 0, CHK_MODEL);
    add_row(spnc_pkg::CH_SLASH, 0, 1, 1, 0, CHK_FAIL);
    // device name
    add_row("c", 1, 0, 1, 0, CHK_MODEL);
    add_row("o", 0, 0, 1, 0, CHK_MODEL);
    add_row("n", 0, 1, 1, 0, CHK_FAIL);
    // no first mark: carries on from the path before
    add_row("b", 0, 1, 1, 0, CHK_MODEL);
    // words without a character, mid path and as the last word
    add_row("x", 1, 0, 1, 0, CHK_MODEL);
    add_row(8'hff, 0, 0, 0, 1, CHK_MODEL);
    add_row("y", 0, 1, 1, 0, CHK_PASS);
    add_row("z", 1, 0, 1, 0, CHK_MODEL);
    add_row(8'h00, 0, 1, 0, 0, CHK_PASS);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      send_word(directed_rows[i].w, directed_rows[i].src);
    end

    path_idx = 0;
    while (words_counted < WORD_TARGET) begin
      path_buf.delete();
      tx_burst = $urandom_range(0, 7) == 0;
      r = $urandom_range(0, 99);
      // lengths around the maximum, plus the odd longer one
      long_len = 0;
      if (path_idx == 20) long_len = MAX_REL;
      else if (path_idx == 40) long_len = MAX_REL + 1;
      else if (path_idx == 60) long_len = MAX_REL - 1;
      else if ($urandom_range(0, 149) == 0) long_len = $urandom_range(MAX_REL + 2, 320);
      if (r < 8 && long_len == 0) begin
        put_noise();
      end else begin
        build_path(long_len);
        if (r < 14) begin
          path_buf[0].first_char = 1'b0;
        end else if (r < 18 && path_buf.size() > 2) begin
          path_buf[$urandom_range(1, path_buf.size() - 2)].first_char = 1'b1;
        end else if (r < 21) begin
          path_buf[path_buf.size() - 1].last_char = 1'b0;
        end
      end
      for (i = 0; i < path_buf.size(); i++) begin
        send_word(path_buf[i], CHK_MODEL);
      end
      path_idx++;
    end
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
